// File: rtl/core/cca_pkg.sv
// Shared types and constants for the circle canvas rasterizer.
// No dependencies; the top level, cca_datapath and cca_ctrl import this package.
`default_nettype none

package cca_pkg;

    // Canvas geometry and fixed-point format
    localparam int MAX_SIDE   = 256;
    localparam int SIDE_BITS  = $clog2(MAX_SIDE);
    localparam int ADDR_BITS  = 2 * SIDE_BITS;
    localparam int DEPTH      = MAX_SIDE * MAX_SIDE;
    localparam int FRAC_BITS  = 8;
    localparam int CHAR_W     = 8;
    localparam int SIZE_W     = 9;
    localparam int COORD_W    = 20;
    localparam int CFG_DATA_W = 9;
    localparam int CFG_IDX_W  = 2;

    // Operand of the squarers: one guard bit over a coordinate
    localparam int OPND_W = COORD_W + 1;
    localparam int SQ_W   = 2 * OPND_W - 1;
    localparam int DIST_W = SQ_W + 1;

    // Operation codes
    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_DRAW  = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_BAD_RADIUS = 2'd1;
    localparam logic [1:0] ST_OUTSIDE    = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BG     = 2'd2;

    typedef struct packed {
        logic [1:0]                operation;
        logic                      filled;
        logic signed [COORD_W-1:0] center_x;
        logic signed [COORD_W-1:0] center_y;
        logic signed [COORD_W-1:0] radius;
        logic [CHAR_W-1:0]         paint_char;
        logic [SIDE_BITS-1:0]      read_row;
        logic [SIDE_BITS-1:0]      read_column;
    } in_item_t;

    typedef struct packed {
        logic [CHAR_W-1:0] pixel_char;
        logic [1:0]        status;
    } out_item_t;

    // Controller to datapath
    typedef struct packed {
        logic load_item;
        logic setup;
        logic sweep_step;
        logic result_load;
    } cca_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [1:0] op;
        logic       radius_bad;
        logic       empty;
        logic       sweep_done;
        logic       writing;
    } cca_stat_t;

endpackage

`default_nettype wire

// File: rtl/core/circle_canvas_rasterizer.sv
// Top level of the circle canvas rasterizer: controller plus datapath.
// Depends on cca_pkg, cca_ctrl, cca_datapath (which holds cca_ram).
`default_nettype none

// The block keeps a 256 x 256 character canvas in one RAM and works on one
// item at a time. A clear or a draw visits every pixel in use, one pixel per
// cycle through the single canvas write port; a draw first squares the
// radius. A clear or a draw on an empty canvas, and a draw with a radius of
// zero or less, skip the sweep. A read does not sweep the canvas. A finished
// result sits in an output register, so the next item is taken as soon as the
// previous one is handed off there. The canvas is not cleared at reset: issue
// a clear before reading pixels.
// Configuration registers may only be written while the block is idle.
module circle_canvas_rasterizer
    import cca_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire in_item_t              in_data,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output out_item_t                  out_data,
    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    cca_cmd_t  cmd;
    cca_stat_t stat;

    cca_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    cca_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_data  (out_data)
    );

    // No canvas write may be in flight when a new item is taken
    a_no_write_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |-> !stat.writing)
        else $error("canvas write while accepting an item");

    // A result is loaded only into a free or draining output register
    a_result_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.result_load |-> (!out_valid || out_ready))
        else $error("result overwrites an item not yet taken");

    // A draw with a bad radius never sweeps the canvas
    a_no_bad_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.sweep_step && (stat.op == OP_DRAW)) |-> !stat.radius_bad)
        else $error("sweep started for a non-positive radius");

    // One item at a time: after an accept, the input side closes
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second item accepted while one is in work");

endmodule

`default_nettype wire

// File: rtl/core/cca_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module cca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: rtl/core/cca_datapath.sv
// Datapath: configuration registers, item register, pixel sweep counters,
// two-stage distance test and the canvas RAM. Depends on cca_pkg, cca_ram.
`default_nettype none

module cca_datapath
    import cca_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire in_item_t              in_data,
    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire cca_cmd_t              cmd,
    output cca_stat_t                  stat,
    output out_item_t                  out_data
);

    logic [SIZE_W-1:0]    width_reg;
    logic [SIZE_W-1:0]    height_reg;
    logic [CHAR_W-1:0]    bg_reg;
    in_item_t             item_reg;
    logic [SIZE_W-1:0]    w_eff;
    logic [SIZE_W-1:0]    h_eff;

    logic [SIDE_BITS-1:0] x_reg;
    logic [SIDE_BITS-1:0] y_reg;
    logic                 last_x;
    logic                 last_y;

    logic [OPND_W-1:0]        x_pos;
    logic [OPND_W-1:0]        y_pos;
    logic signed [OPND_W-1:0] dx;
    logic signed [OPND_W-1:0] dy;
    logic signed [OPND_W-1:0] r_ext;
    logic signed [OPND_W-1:0] inner;
    logic signed [OPND_W-1:0] sq_a_op;
    logic signed [OPND_W-1:0] sq_b_op;
    logic signed [2*OPND_W-1:0] sq_a_prod;
    logic signed [2*OPND_W-1:0] sq_b_prod;
    logic [SQ_W-1:0]          sq_a_reg;
    logic [SQ_W-1:0]          sq_b_reg;
    logic [SQ_W-1:0]          r2_reg;
    logic [SQ_W-1:0]          inner2_reg;
    logic                     has_inner_reg;
    logic                     setup_d_reg;

    logic                 st_valid_reg;
    logic [ADDR_BITS-1:0] st_addr_reg;
    logic [DIST_W-1:0]    dist2;
    logic                 covered;
    logic                 on_edge;

    logic                 ram_we;
    logic [CHAR_W-1:0]    ram_wdata;
    logic [CHAR_W-1:0]    ram_rdata;
    logic                 read_outside;
    out_item_t            out_next;
    out_item_t            out_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= SIZE_W'(1);
            height_reg <= SIZE_W'(1);
            bg_reg     <= CHAR_W'(32);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_WIDTH:  width_reg  <= cfg_data[SIZE_W-1:0];
                CFG_HEIGHT: height_reg <= cfg_data[SIZE_W-1:0];
                CFG_BG:     bg_reg     <= cfg_data[CHAR_W-1:0];
                default:    ;
            endcase
        end
    end

    assign w_eff = (width_reg > SIZE_W'(MAX_SIDE)) ? SIZE_W'(MAX_SIDE) : width_reg;
    assign h_eff = (height_reg > SIZE_W'(MAX_SIDE)) ? SIZE_W'(MAX_SIDE) : height_reg;

    // Item register and sweep counters
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_reg <= in_data;
            x_reg    <= '0;
            y_reg    <= '0;
        end
        else if (cmd.sweep_step)
        begin
            if (last_x)
            begin
                x_reg <= '0;
                y_reg <= y_reg + 1'b1;
            end
            else
            begin
                x_reg <= x_reg + 1'b1;
            end
        end
    end

    assign last_x = ({1'b0, x_reg} == (w_eff - SIZE_W'(1)));
    assign last_y = ({1'b0, y_reg} == (h_eff - SIZE_W'(1)));

    // Stage A: offsets to the centre, squared
    assign x_pos = OPND_W'(x_reg) << FRAC_BITS;
    assign y_pos = OPND_W'(y_reg) << FRAC_BITS;
    assign dx    = $signed(x_pos) - $signed({item_reg.center_x[COORD_W-1], item_reg.center_x});
    assign dy    = $signed(y_pos) - $signed({item_reg.center_y[COORD_W-1], item_reg.center_y});
    assign r_ext = $signed({item_reg.radius[COORD_W-1], item_reg.radius});
    assign inner = r_ext - $signed(OPND_W'(1) << FRAC_BITS);

    // The squarers take the radius terms during setup
    assign sq_a_op   = cmd.setup ? r_ext : dx;
    assign sq_b_op   = cmd.setup ? inner : dy;
    assign sq_a_prod = sq_a_op * sq_a_op;
    assign sq_b_prod = sq_b_op * sq_b_op;

    always_ff @(posedge clk)
    begin
        if (cmd.setup || cmd.sweep_step)
        begin
            sq_a_reg <= sq_a_prod[SQ_W-1:0];
            sq_b_reg <= sq_b_prod[SQ_W-1:0];
        end
        if (cmd.setup)
        begin
            has_inner_reg <= !inner[OPND_W-1];
        end
        if (setup_d_reg)
        begin
            r2_reg     <= sq_a_reg;
            inner2_reg <= sq_b_reg;
        end
        st_addr_reg <= {y_reg, x_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            setup_d_reg  <= 1'b0;
            st_valid_reg <= 1'b0;
        end
        else
        begin
            setup_d_reg  <= cmd.setup;
            st_valid_reg <= cmd.sweep_step;
        end
    end

    // Stage B: compare and write
    assign dist2   = DIST_W'(sq_a_reg) + DIST_W'(sq_b_reg);
    assign covered = (dist2 <= DIST_W'(r2_reg));
    assign on_edge = covered && (!has_inner_reg || (dist2 > DIST_W'(inner2_reg)));

    always_comb
    begin
        ram_we    = 1'b0;
        ram_wdata = item_reg.paint_char;
        if (st_valid_reg)
        begin
            if (item_reg.operation == OP_CLEAR)
            begin
                ram_we    = 1'b1;
                ram_wdata = bg_reg;
            end
            else
            begin
                ram_we = item_reg.filled ? covered : on_edge;
            end
        end
    end

    cca_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (DEPTH)
    ) u_canvas (
        .clk   (clk),
        .we    (ram_we),
        .waddr (st_addr_reg),
        .wdata (ram_wdata),
        .raddr ({item_reg.read_row, item_reg.read_column}),
        .rdata (ram_rdata)
    );

    // Result
    assign read_outside = ({1'b0, item_reg.read_row} >= h_eff)
                       || ({1'b0, item_reg.read_column} >= w_eff);

    always_comb
    begin
        out_next.pixel_char = '0;
        out_next.status     = ST_OK;
        case (item_reg.operation)
            OP_DRAW:
            begin
                if (stat.radius_bad)
                begin
                    out_next.status = ST_BAD_RADIUS;
                end
            end
            OP_READ:
            begin
                if (read_outside)
                begin
                    out_next.status = ST_OUTSIDE;
                end
                else
                begin
                    out_next.pixel_char = ram_rdata;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.result_load)
        begin
            out_reg <= out_next;
        end
    end

    assign out_data = out_reg;

    assign stat.op           = item_reg.operation;
    assign stat.radius_bad   = item_reg.radius[COORD_W-1] || (item_reg.radius == '0);
    assign stat.empty        = (w_eff == '0) || (h_eff == '0);
    assign stat.sweep_done   = last_x && last_y;
    assign stat.writing      = ram_we;

endmodule

`default_nettype wire

// File: rtl/core/cca_ctrl.sv
// Controller: sequences one item at a time through decode, radius setup,
// pixel sweep, pipeline drain and result hand-off. Depends on cca_pkg.
`default_nettype none

module cca_ctrl
    import cca_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  wire logic      out_ready,
    input  wire cca_stat_t stat,
    output cca_cmd_t       cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_SETUP  = 3'd2;
    localparam logic [2:0] S_SWEEP  = 3'd3;
    localparam logic [2:0] S_DRAIN  = 3'd4;
    localparam logic [2:0] S_FINISH = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_comb
    begin
        state_next      = state_reg;
        cmd             = '0;
        out_valid_next  = out_valid_reg && !out_ready;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (stat.op)
                    OP_CLEAR: state_next = stat.empty ? S_FINISH : S_SWEEP;
                    OP_DRAW:  state_next = (stat.radius_bad || stat.empty) ? S_FINISH : S_SETUP;
                    default:  state_next = S_FINISH;
                endcase
            end
            S_SETUP:
            begin
                cmd.setup  = 1'b1;
                state_next = S_SWEEP;
            end
            S_SWEEP:
            begin
                cmd.sweep_step = 1'b1;
                if (stat.sweep_done)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.result_load = 1'b1;
                    out_valid_next  = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire
